@@ src/wavetable_oscillator_crossfade_top_defines.svh @@
// Assertion macros used by the oscillator's top level
`ifndef WAVETABLE_OSCILLATOR_CROSSFADE_TOP_DEFINES_SVH
`define WAVETABLE_OSCILLATOR_CROSSFADE_TOP_DEFINES_SVH

// antecedent holds -> consequent in the same cycle
`define WOC_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// antecedent holds -> consequent in the next cycle
`define WOC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

@@ src/woc_pkg.sv @@
// Shared types, codes and constants of the wavetable oscillator
`default_nettype none

package woc_pkg;

  localparam int TABLE_DEPTH_DEF  = 8192;
  localparam int QSINE_DEPTH_DEF  = 1024;
  localparam int SAMPLE_W         = 24;
  localparam int FADE_W           = 24;
  localparam int SINE_W           = 18;
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam logic [63:0] SINE_ONE    = 64'd131072;

  typedef enum logic [1:0] {
    CMD_TICK   = 2'd0,
    CMD_WRITE  = 2'd1,
    CMD_COMMIT = 2'd2,
    CMD_NOP    = 2'd3
  } cmd_e;

  localparam logic [1:0] FADE_NONE   = 2'd0;
  localparam logic [1:0] FADE_LINEAR = 2'd1;
  localparam logic [1:0] FADE_POWER  = 2'd2;

  localparam logic [1:0] REG_INTERP   = 2'd0;
  localparam logic [1:0] REG_FTYPE    = 2'd1;
  localparam logic [1:0] REG_FLEN     = 2'd2;
  localparam logic [1:0] REG_MUTE     = 2'd3;

  localparam logic [1:0]        FTYPE_RST = FADE_LINEAR;
  localparam logic [FADE_W-1:0] FLEN_RST  = 24'd2205;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_TAKE,
    OP_POS,
    OP_RD_N1,
    OP_RD_N2,
    OP_RD_O1,
    OP_RD_O2,
    OP_RD_LAST,
    OP_INT_MUL,
    OP_INT_ADD,
    OP_SINE_K,
    OP_SINE_RD0,
    OP_SINE_RD1,
    OP_SINE_RD2,
    OP_MIX_MUL,
    OP_MIX_ADD,
    OP_FINISH
  } dp_op_e;

  typedef struct packed {
    dp_op_e op;
  } ctl_cmd_t;

  typedef struct packed {
    cmd_e       in_cmd;
    logic       mute;
    logic       fading;
    logic [1:0] fade_type;
    logic       div_busy;
    logic       out_full;
  } ctl_status_t;

endpackage

`default_nettype wire

@@ src/wavetable_oscillator_crossfade_top.sv @@
// Top level of the ping-pong wavetable oscillator with bank crossfade
//
// Input stream (s_axis): one request per handshake. tuser carries the command
// (sample tick, write to the idle bank, commit/swap); tdata carries the phase
// increment, phase offset, table index and table value. Only ticks produce a
// result on m_axis: tdata is the Q1.23 sample, tuser the fading flag.
// Configuration (cfg_*): index 0 interpolate, 1 fade type, 2 fade length,
// 3 mute; always ready, write only while no request is in flight.
// Steps: writes, commits and unused commands finish at the accept. A muted
// tick goes straight to the output load; a plain tick runs the phase multiply,
// three read slots on the single registered bank port, the interpolation
// multiply and add, and the output load. A fading tick reads both banks and
// waits on the restoring divider for the fade weight, then mixes linear or
// equal-power (or skips the mix with no fade type); with a zero weight the
// divider is skipped.
// Reset: banks stay undefined until written; phase, fade count and bank
// select clear, registers return to their defaults (fade linear, 2205).
// Back-pressure: the result sits in an output register; the next request is
// accepted meanwhile and only stalls at its own output load.
`default_nettype none
`include "wavetable_oscillator_crossfade_top_defines.svh"

module wavetable_oscillator_crossfade_top #(
  parameter int TABLE_DEPTH        = woc_pkg::TABLE_DEPTH_DEF,
  parameter int QUARTER_SINE_DEPTH = woc_pkg::QSINE_DEPTH_DEF
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  // [31:0] phase increment, [63:32] phase shift, [76:64] table index,
  // [100:77] table value, [103:101] zero
  input  wire logic [103:0] s_axis_tdata,
  // [1:0] command
  input  wire logic [1:0]   s_axis_tuser,
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // [23:0] sample
  output logic [23:0]       m_axis_tdata,
  // [0] fading
  output logic              m_axis_tuser,
  input  wire logic         cfg_valid_i,
  output logic              cfg_ready_o,
  input  wire logic [1:0]   cfg_index_i,
  input  wire logic [23:0]  cfg_data_i
);

  woc_pkg::ctl_cmd_t    ctl;
  woc_pkg::ctl_status_t status;

  assign cfg_ready_o = 1'b1;

  woc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .status_i   (status),
    .ctl_o      (ctl)
  );

  woc_datapath #(
    .TABLE_DEPTH        (TABLE_DEPTH),
    .QUARTER_SINE_DEPTH (QUARTER_SINE_DEPTH)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .ctl_i          (ctl),
    .status_o       (status),
    .in_command_i   (s_axis_tuser),
    .in_increment_i (s_axis_tdata[31:0]),
    .in_offset_i    (s_axis_tdata[63:32]),
    .in_index_i     (s_axis_tdata[76:64]),
    .in_value_i     (s_axis_tdata[100:77]),
    .cfg_we_i       (cfg_valid_i && cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .out_ready_i    (m_axis_tready),
    .out_valid_o    (m_axis_tvalid),
    .out_sample_o   (m_axis_tdata),
    .out_fading_o   (m_axis_tuser)
  );

  // divider must have finished whenever a new request can be taken
  `WOC_ASSERT_NOW(a_div_idle, clk_i, rst_ni, s_axis_tready, !status.div_busy)
  // a table write completes in its accept cycle
  `WOC_ASSERT_NEXT(a_write_single, clk_i, rst_ni,
    s_axis_tvalid && s_axis_tready && (s_axis_tuser == woc_pkg::CMD_WRITE), s_axis_tready)
  // the datapath only loads the output register when it is free
  `WOC_ASSERT_NOW(a_load_free, clk_i, rst_ni, ctl.op == woc_pkg::OP_FINISH,
    !(m_axis_tvalid && !m_axis_tready))

endmodule

`default_nettype wire

@@ src/woc_divider.sv @@
// Restoring divider for the crossfade weight, one quotient bit a cycle
`default_nettype none

module woc_divider (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start_i,
  input  wire logic [woc_pkg::FADE_W-1:0]    dividend_i,
  input  wire logic [woc_pkg::FADE_W-1:0]    divisor_i,
  output logic                               busy_o,
  output logic [woc_pkg::FADE_W-1:0]         quotient_o
);

  localparam int W  = woc_pkg::FADE_W;
  localparam int CW = $clog2(W + 1);

  logic [CW-1:0] cnt_q, cnt_d;
  logic [W-1:0]  rem_q, rem_d, dsr_q, dsr_d, quo_q, quo_d;
  logic [W:0]    r2, r2_sub;
  logic          ge;

  // dividend is already below the divisor, so W shifts give W quotient bits
  always_comb begin
    r2     = {rem_q, 1'b0};
    r2_sub = r2 - {1'b0, dsr_q};
    ge     = r2 >= {1'b0, dsr_q};
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    dsr_d  = dsr_q;
    quo_d  = quo_q;
    if (start_i) begin
      cnt_d = CW'(W);
      rem_d = dividend_i;
      dsr_d = divisor_i;
      quo_d = '0;
    end else if (cnt_q != '0) begin
      cnt_d = cnt_q - 1'b1;
      rem_d = ge ? r2_sub[W-1:0] : r2[W-1:0];
      quo_d = {quo_q[W-2:0], ge};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dsr_q <= dsr_d;
    quo_q <= quo_d;
  end

  assign busy_o     = cnt_q != '0;
  assign quotient_o = quo_q;

endmodule

`default_nettype wire

@@ src/woc_datapath.sv @@
// Oscillator datapath: registers, table banks, sine ROM, interpolation and mixing
`default_nettype none

module woc_datapath #(
  parameter int TABLE_DEPTH        = woc_pkg::TABLE_DEPTH_DEF,
  parameter int QUARTER_SINE_DEPTH = woc_pkg::QSINE_DEPTH_DEF
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire woc_pkg::ctl_cmd_t              ctl_i,
  output woc_pkg::ctl_status_t                status_o,
  input  wire logic [1:0]                     in_command_i,
  input  wire logic [31:0]                    in_increment_i,
  input  wire logic [31:0]                    in_offset_i,
  input  wire logic [12:0]                    in_index_i,
  input  wire logic [woc_pkg::SAMPLE_W-1:0]   in_value_i,
  input  wire logic                           cfg_we_i,
  input  wire logic [1:0]                     cfg_index_i,
  input  wire logic [23:0]                    cfg_data_i,
  input  wire logic                           out_ready_i,
  output logic                                out_valid_o,
  output logic [woc_pkg::SAMPLE_W-1:0]        out_sample_o,
  output logic                                out_fading_o
);

  localparam int SW  = woc_pkg::SAMPLE_W;
  localparam int FW  = woc_pkg::FADE_W;
  localparam int QW  = woc_pkg::SINE_W;
  localparam int IW  = $clog2(TABLE_DEPTH);
  localparam int MD  = 2 * TABLE_DEPTH;
  localparam int MAW = $clog2(MD);
  localparam int TDW = $clog2(TABLE_DEPTH + 1);
  localparam int PW  = 32 + TDW;
  localparam int RW  = $clog2(QUARTER_SINE_DEPTH);
  localparam int KW  = $clog2(QUARTER_SINE_DEPTH + 1);
  localparam int KPW = FW + KW;
  localparam int PNW = SW + 1 + 33;
  localparam int MW  = 26 + SW;

  typedef logic [QW-1:0] rom_t [QUARTER_SINE_DEPTH];

  // round(2^17 * sin(pi/2 * k / depth)) from a Q30 Taylor series
  function automatic rom_t build_rom();
    rom_t        r;
    logic [63:0] x, term, sum, v;
    for (int k = 0; k < QUARTER_SINE_DEPTH; k++) begin
      x    = 64'(k) * woc_pkg::HALF_PI_Q30 / 64'(QUARTER_SINE_DEPTH);
      term = x;
      sum  = x;
      for (int n = 1; n <= 10; n++) begin
        term = (((term * x) >> 30) * x) >> 30;
        term = term / 64'((2 * n) * (2 * n + 1));
        sum  = n[0] ? sum - term : sum + term;
      end
      v    = (sum * woc_pkg::SINE_ONE + (64'd1 << 29)) >> 30;
      r[k] = (v > woc_pkg::SINE_ONE) ? QW'(woc_pkg::SINE_ONE) : v[QW-1:0];
    end
    return r;
  endfunction

  localparam rom_t SINE_ROM = build_rom();

  woc_pkg::dp_op_e op;
  assign op = ctl_i.op;

  // configuration
  logic             interp_q, mute_q;
  logic [1:0]       ftype_q;
  logic [FW-1:0]    flen_q;
  // oscillator state
  logic             act_q;
  logic [31:0]      acc_q;
  logic [FW-1:0]    fr_q;
  // per-tick working registers
  logic [31:0]      inc_q, off_q;
  logic             fading_q, muted_q, elig_q;
  logic [PW-1:0]    pos_q;
  logic [SW-1:0]    rd_q, ns1_q, ns2_q, os1_q, os2_q, nv_q, ov_q, res_q;
  logic signed [PNW-1:0] pn_q, po_q;
  logic [KW-1:0]    k_q;
  logic [QW-1:0]    rom_q, sa_q, sb_q;
  logic signed [MW-1:0] ma_q, mb_q;
  logic             out_valid_q, out_fading_q;
  logic [SW-1:0]    out_sample_q;

  logic [SW-1:0]    mem [MD];

  logic             take, tick_take;
  logic [31:0]      ph, ti32;
  logic [PW-1:0]    pos_d;
  logic [IW-1:0]    idx, idx2;
  logic [IW:0]      idx_inc;
  logic [MAW-1:0]   raddr, waddr, base_act, base_idle;
  logic             we, commit_ok, elig;
  logic [FW-1:0]    m1, dvd;
  logic             div_start, div_busy;
  logic [FW-1:0]    quo;
  logic [KPW-1:0]   kp;
  logic [KW-1:0]    sine_idx;
  logic [RW-1:0]    raddr_rom;
  logic [24:0]      wa, wb;
  logic signed [PNW-1:0] pn_d, po_d;
  logic [25:0]      nv_sum, ov_sum;
  logic signed [MW:0]   mix_sum, mix_sh;
  logic [SW-1:0]    mix_sat;

  assign take      = op == woc_pkg::OP_TAKE;
  assign tick_take = take && (woc_pkg::cmd_e'(in_command_i) == woc_pkg::CMD_TICK);

  assign base_act  = act_q ? MAW'(TABLE_DEPTH) : '0;
  assign base_idle = act_q ? '0 : MAW'(TABLE_DEPTH);

  assign ti32  = 32'(in_index_i);
  assign waddr = base_idle + MAW'(ti32[IW-1:0]);
  assign we    = take && (woc_pkg::cmd_e'(in_command_i) == woc_pkg::CMD_WRITE) && !mute_q
                 && (fr_q == '0) && (ti32 < 32'(TABLE_DEPTH));
  assign commit_ok = take && (woc_pkg::cmd_e'(in_command_i) == woc_pkg::CMD_COMMIT)
                     && !mute_q && (fr_q == '0);

  assign ph      = acc_q + off_q;
  assign pos_d   = PW'(ph) * PW'(TABLE_DEPTH);
  assign idx     = pos_q[32 +: IW];
  assign idx_inc = {1'b0, idx} + 1'b1;
  assign idx2    = (idx_inc >= (IW+1)'(TABLE_DEPTH)) ? '0 : idx_inc[IW-1:0];

  always_comb begin
    case (op)
      woc_pkg::OP_RD_N2: raddr = base_act  + MAW'(idx2);
      woc_pkg::OP_RD_O1: raddr = base_idle + MAW'(idx);
      woc_pkg::OP_RD_O2: raddr = base_idle + MAW'(idx2);
      default:           raddr = base_act  + MAW'(idx);
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= in_value_i;
    end
    rd_q <= mem[raddr];
  end

  // crossfade weight m1 = (len - remaining) * 2^24 / len
  assign elig      = (flen_q != '0) && (fr_q < flen_q);
  assign dvd       = flen_q - fr_q;
  assign div_start = (op == woc_pkg::OP_POS) && (fr_q != '0) && elig;
  assign m1        = elig_q ? quo : '0;

  woc_divider u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (dvd),
    .divisor_i  (flen_q),
    .busy_o     (div_busy),
    .quotient_o (quo)
  );

  // equal-power ROM index, rounded
  assign kp = KPW'(m1) * KPW'(QUARTER_SINE_DEPTH) + (KPW'(1) << 23);

  always_comb begin
    sine_idx = (op == woc_pkg::OP_SINE_RD1) ? KW'(QUARTER_SINE_DEPTH) - k_q : k_q;
    if (sine_idx >= KW'(QUARTER_SINE_DEPTH)) begin
      raddr_rom = '0;
    end else begin
      raddr_rom = sine_idx[RW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    rom_q <= SINE_ROM[raddr_rom];
  end

  // interpolation
  assign pn_d = ($signed({ns2_q[SW-1], ns2_q}) - $signed({ns1_q[SW-1], ns1_q}))
                * $signed({1'b0, pos_q[31:0]});
  assign po_d = ($signed({os2_q[SW-1], os2_q}) - $signed({os1_q[SW-1], os1_q}))
                * $signed({1'b0, pos_q[31:0]});
  assign nv_sum = {{2{ns1_q[SW-1]}}, ns1_q} + 26'(pn_q >>> 32);
  assign ov_sum = {{2{os1_q[SW-1]}}, os1_q} + 26'(po_q >>> 32);

  // mixing weights
  always_comb begin
    if (ftype_q == woc_pkg::FADE_POWER) begin
      wa = 25'(sa_q);
      wb = 25'(sb_q);
    end else begin
      wa = 25'(m1);
      wb = (25'd1 << 24) - 25'(m1);
    end
  end

  assign mix_sum = {ma_q[MW-1], ma_q} + {mb_q[MW-1], mb_q};
  assign mix_sh  = (ftype_q == woc_pkg::FADE_POWER) ? (mix_sum >>> 17) : (mix_sum >>> 24);

  always_comb begin
    if (!mix_sh[MW] && (mix_sh[MW-1:SW-1] != '0)) begin
      mix_sat = {1'b0, {(SW-1){1'b1}}};
    end else if (mix_sh[MW] && (mix_sh[MW-1:SW-1] != '1)) begin
      mix_sat = {1'b1, {(SW-1){1'b0}}};
    end else begin
      mix_sat = mix_sh[SW-1:0];
    end
  end

  // working registers, no reset needed
  always_ff @(posedge clk_i) begin
    case (op)
      woc_pkg::OP_TAKE: begin
        inc_q <= in_increment_i;
        off_q <= in_offset_i;
        res_q <= '0;
      end
      woc_pkg::OP_POS: begin
        pos_q  <= pos_d;
        elig_q <= elig;
      end
      woc_pkg::OP_RD_N2:   ns1_q <= rd_q;
      woc_pkg::OP_RD_O1:   ns2_q <= rd_q;
      woc_pkg::OP_RD_O2:   os1_q <= rd_q;
      woc_pkg::OP_RD_LAST: os2_q <= rd_q;
      woc_pkg::OP_INT_MUL: begin
        pn_q <= pn_d;
        po_q <= po_d;
      end
      woc_pkg::OP_INT_ADD: begin
        nv_q  <= interp_q ? nv_sum[SW-1:0] : ns1_q;
        ov_q  <= interp_q ? ov_sum[SW-1:0] : os1_q;
        res_q <= interp_q ? nv_sum[SW-1:0] : ns1_q;
      end
      woc_pkg::OP_SINE_K:   k_q <= kp[FW +: KW];
      woc_pkg::OP_SINE_RD1: sa_q <= (k_q == KW'(QUARTER_SINE_DEPTH)) ?
                                    QW'(woc_pkg::SINE_ONE) : rom_q;
      woc_pkg::OP_SINE_RD2: sb_q <= (k_q == '0) ? QW'(woc_pkg::SINE_ONE) : rom_q;
      woc_pkg::OP_MIX_MUL: begin
        ma_q <= $signed({1'b0, wa}) * $signed(nv_q);
        mb_q <= $signed({1'b0, wb}) * $signed(ov_q);
      end
      woc_pkg::OP_MIX_ADD: res_q <= mix_sat;
      default: ;
    endcase
    if (op == woc_pkg::OP_FINISH) begin
      out_sample_q <= res_q;
      out_fading_q <= fading_q;
    end
  end

  // control and architectural state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      interp_q    <= 1'b0;
      ftype_q     <= woc_pkg::FTYPE_RST;
      flen_q      <= woc_pkg::FLEN_RST;
      mute_q      <= 1'b0;
      act_q       <= 1'b0;
      acc_q       <= '0;
      fr_q        <= '0;
      fading_q    <= 1'b0;
      muted_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          woc_pkg::REG_INTERP: interp_q <= cfg_data_i[0];
          woc_pkg::REG_FTYPE:  ftype_q  <= cfg_data_i[1:0];
          woc_pkg::REG_FLEN:   flen_q   <= cfg_data_i;
          woc_pkg::REG_MUTE:   mute_q   <= cfg_data_i[0];
          default: ;
        endcase
      end
      if (tick_take) begin
        fading_q <= fr_q != '0;
        muted_q  <= mute_q;
      end
      if (commit_ok) begin
        act_q <= ~act_q;
        if (((ftype_q == woc_pkg::FADE_LINEAR) || (ftype_q == woc_pkg::FADE_POWER))
            && (flen_q != '0)) begin
          fr_q <= flen_q;
        end
      end
      if (op == woc_pkg::OP_FINISH) begin
        out_valid_q <= 1'b1;
        if (!muted_q) begin
          acc_q <= acc_q + inc_q;
          if (fading_q) begin
            fr_q <= fr_q - 1'b1;
          end
        end
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign status_o.in_cmd    = woc_pkg::cmd_e'(in_command_i);
  assign status_o.mute      = mute_q;
  assign status_o.fading    = fading_q;
  assign status_o.fade_type = ftype_q;
  assign status_o.div_busy  = div_busy;
  assign status_o.out_full  = out_valid_q && !out_ready_i;

  assign out_valid_o  = out_valid_q;
  assign out_sample_o = out_sample_q;
  assign out_fading_o = out_fading_q;

endmodule

`default_nettype wire

@@ src/woc_ctrl.sv @@
// Sequencer for the oscillator: steps the datapath through one request
`default_nettype none

module woc_ctrl (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_ready_o,
  input  wire woc_pkg::ctl_status_t  status_i,
  output woc_pkg::ctl_cmd_t          ctl_o
);

  localparam logic [4:0] ST_IDLE     = 5'd0;
  localparam logic [4:0] ST_POS      = 5'd1;
  localparam logic [4:0] ST_RD_N1    = 5'd2;
  localparam logic [4:0] ST_RD_N2    = 5'd3;
  localparam logic [4:0] ST_RD_O1    = 5'd4;
  localparam logic [4:0] ST_RD_O2    = 5'd5;
  localparam logic [4:0] ST_RD_LAST  = 5'd6;
  localparam logic [4:0] ST_INT_MUL  = 5'd7;
  localparam logic [4:0] ST_INT_ADD  = 5'd8;
  localparam logic [4:0] ST_WAIT_DIV = 5'd9;
  localparam logic [4:0] ST_SINE_K   = 5'd10;
  localparam logic [4:0] ST_SINE_RD0 = 5'd11;
  localparam logic [4:0] ST_SINE_RD1 = 5'd12;
  localparam logic [4:0] ST_SINE_RD2 = 5'd13;
  localparam logic [4:0] ST_MIX_MUL  = 5'd14;
  localparam logic [4:0] ST_MIX_ADD  = 5'd15;
  localparam logic [4:0] ST_FINISH   = 5'd16;

  logic [4:0] state_q, state_d;

  always_comb begin
    state_d    = state_q;
    ctl_o.op   = woc_pkg::OP_NONE;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          ctl_o.op = woc_pkg::OP_TAKE;
          if (status_i.in_cmd == woc_pkg::CMD_TICK) begin
            state_d = status_i.mute ? ST_FINISH : ST_POS;
          end
        end
      end
      ST_POS: begin
        ctl_o.op = woc_pkg::OP_POS;
        state_d  = ST_RD_N1;
      end
      ST_RD_N1: begin
        ctl_o.op = woc_pkg::OP_RD_N1;
        state_d  = ST_RD_N2;
      end
      ST_RD_N2: begin
        ctl_o.op = woc_pkg::OP_RD_N2;
        state_d  = ST_RD_O1;
      end
      ST_RD_O1: begin
        ctl_o.op = woc_pkg::OP_RD_O1;
        state_d  = status_i.fading ? ST_RD_O2 : ST_INT_MUL;
      end
      ST_RD_O2: begin
        ctl_o.op = woc_pkg::OP_RD_O2;
        state_d  = ST_RD_LAST;
      end
      ST_RD_LAST: begin
        ctl_o.op = woc_pkg::OP_RD_LAST;
        state_d  = ST_INT_MUL;
      end
      ST_INT_MUL: begin
        ctl_o.op = woc_pkg::OP_INT_MUL;
        state_d  = ST_INT_ADD;
      end
      ST_INT_ADD: begin
        ctl_o.op = woc_pkg::OP_INT_ADD;
        state_d  = status_i.fading ? ST_WAIT_DIV : ST_FINISH;
      end
      ST_WAIT_DIV: begin
        if (!status_i.div_busy) begin
          case (status_i.fade_type)
            woc_pkg::FADE_LINEAR: state_d = ST_MIX_MUL;
            woc_pkg::FADE_POWER:  state_d = ST_SINE_K;
            default:              state_d = ST_FINISH;
          endcase
        end
      end
      ST_SINE_K: begin
        ctl_o.op = woc_pkg::OP_SINE_K;
        state_d  = ST_SINE_RD0;
      end
      ST_SINE_RD0: begin
        ctl_o.op = woc_pkg::OP_SINE_RD0;
        state_d  = ST_SINE_RD1;
      end
      ST_SINE_RD1: begin
        ctl_o.op = woc_pkg::OP_SINE_RD1;
        state_d  = ST_SINE_RD2;
      end
      ST_SINE_RD2: begin
        ctl_o.op = woc_pkg::OP_SINE_RD2;
        state_d  = ST_MIX_MUL;
      end
      ST_MIX_MUL: begin
        ctl_o.op = woc_pkg::OP_MIX_MUL;
        state_d  = ST_MIX_ADD;
      end
      ST_MIX_ADD: begin
        ctl_o.op = woc_pkg::OP_MIX_ADD;
        state_d  = ST_FINISH;
      end
      ST_FINISH: begin
        if (!status_i.out_full) begin
          ctl_o.op = woc_pkg::OP_FINISH;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire
